[sv/stem_transition_crossfade_core_macros.svh]
// ----------------------------------------------------------------------------
// stem_transition_crossfade_core_macros
// assertion macros shared by the crossfade core, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef STEM_TRANSITION_CROSSFADE_CORE_MACROS_SVH
`define STEM_TRANSITION_CROSSFADE_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define STCF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define STCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/stcf_pkg.sv]
// ----------------------------------------------------------------------------
// stcf_pkg
// types and constants of the stem transition crossfade core
// ----------------------------------------------------------------------------
`default_nettype none

package stcf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int STEM_W   = 3;
	localparam int REQ_W    = 2;
	// weight is unsigned q2.15, wide enough to hold 1.0
	localparam int FRAC     = 15;
	localparam int W_W      = FRAC + 2;
	localparam logic [W_W-1:0] W_ONE = W_W'(1) << FRAC;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [W_W-1:0] weight_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_START  = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [STEM_W-1:0] stem_index;
		sample_t           sample_left;
		sample_t           sample_right;
		logic              frame_end;
	} in_item_t;

	typedef struct packed {
		logic [STEM_W-1:0] stem_out;
		sample_t           out_left;
		sample_t           out_right;
		logic              blending;
	} out_item_t;

endpackage

`default_nettype wire

[sv/stcf_chan_if.sv]
// ----------------------------------------------------------------------------
// stcf_chan_if
// valid/ready channel carrying one word of type T per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface stcf_chan_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

[sv/stcf_weight_rom.sv]
// ----------------------------------------------------------------------------
// stcf_weight_rom
// crossfade weight table sqrt(frames / length) in q1.15, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module stcf_weight_rom import stcf_pkg::*; #(
	parameter int BLEND_LENGTH = 256,
	parameter int FL_W = 9
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [FL_W-1:0] addr,
	output weight_t              weight
);

	// floor(32768 * sqrt(f / BLEND_LENGTH)), evaluated per entry at elaboration
	function automatic weight_t weight_of(input int unsigned f);
		longint unsigned q;
		longint unsigned res;
		longint unsigned b;
		q   = (longint'(f) << 30) / BLEND_LENGTH;
		res = 0;
		b   = longint'(1) << 30;
		for (int k = 0; k < 16; k++) begin
			if (q >= res + b) begin
				q   = q - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return W_W'(res);
	endfunction

	weight_t wtab [0:BLEND_LENGTH];
	weight_t weight_q;

	for (genvar g = 0; g <= BLEND_LENGTH; g++) begin : g_tab
		assign wtab[g] = weight_of(g);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else begin
			weight_q <= wtab[addr];
		end
	end

	assign weight = weight_q;

endmodule

`default_nettype wire

[sv/stcf_blend_lane.sv]
// ----------------------------------------------------------------------------
// stcf_blend_lane
// one channel of the crossfade: live + floor(w * (held - live) / 2^15)
// ----------------------------------------------------------------------------
`default_nettype none

module stcf_blend_lane import stcf_pkg::*; (
	input  wire sample_t live,
	input  wire sample_t held,
	input  wire weight_t weight,
	output sample_t      blended
);

	localparam int DW = SAMPLE_W + 1;
	localparam int PW = W_W + 1 + DW;
	localparam int SW = PW - FRAC;

	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod;
	logic signed [SW-1:0] step;
	logic signed [SW-1:0] sum;

	assign diff = DW'(held) - DW'(live);
	assign prod = $signed({1'b0, weight}) * diff;
	// arithmetic shift gives the floor for negative products
	assign step = SW'(prod >>> FRAC);
	assign sum  = step + SW'(live);
	// result lies between live and held, so the top bits are sign copies
	assign blended = SAMPLE_W'(sum);

endmodule

`default_nettype wire

[sv/stem_transition_crossfade_core.sv]
// ----------------------------------------------------------------------------
// stem_transition_crossfade_core
// Channel items (sink) takes request words: a stem sample, a start of
// transition, or a clear of the remembered samples. Channel results (source)
// gives one word per stem sample whose stem index is below STEM_COUNT; start,
// clear and unused request codes give none.
// Each stem's last incoming sample is remembered. A start copies all of them
// into held values and loads a countdown of BLEND_LENGTH frames; while it is
// nonzero each sample is blended from the held value toward the live one,
// weighted by sqrt(frames_left / BLEND_LENGTH). frame_end on a sample word
// counts the countdown down.
// Pipeline: the sample is taken into the input register, then one multiply and
// add per lane feeds the output register, which presents the result.
// Throughput: one word per cycle while results is not stalled; the weight table
// lookup is registered from the next countdown value, so it adds no latency.
// Reset clears the remembered and held samples, the countdown and the
// pipeline. When results is stalled the output word holds and the input
// register fills; ready drops only while both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stem_transition_crossfade_core_macros.svh"

module stem_transition_crossfade_core import stcf_pkg::*; #(
	parameter int BLEND_LENGTH = 256,
	parameter int STEM_COUNT = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stcf_chan_if.sink   items,
	stcf_chan_if.source results
);

	localparam int FL_W  = $clog2(BLEND_LENGTH + 1);
	localparam int IDX_W = (STEM_COUNT > 1) ? $clog2(STEM_COUNT) : 1;

	// remembered and held samples
	sample_t last_l_q [STEM_COUNT];
	sample_t last_r_q [STEM_COUNT];
	sample_t held_l_q [STEM_COUNT];
	sample_t held_r_q [STEM_COUNT];

	logic [FL_W-1:0] frames_left_q;
	logic [FL_W-1:0] frames_next;
	weight_t         w_cur;

	logic             accept;
	logic             stem_ok;
	logic [IDX_W-1:0] stem_idx;
	logic             is_sample;
	logic             is_start;
	logic             adv_s1;
	logic             adv_s2;

	// input register stage
	logic              valid_s1;
	logic [STEM_W-1:0] stem_s1;
	sample_t           live_l_s1;
	sample_t           live_r_s1;
	sample_t           held_l_s1;
	sample_t           held_r_s1;
	weight_t           w_s1;
	logic              active_s1;

	// output register stage
	logic      valid_s2;
	out_item_t out_s2;
	sample_t   blend_l;
	sample_t   blend_r;

	assign adv_s2      = !valid_s2 || results.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign items.ready = adv_s1;
	assign accept      = items.valid && adv_s1;

	assign stem_idx  = IDX_W'(items.payload.stem_index);
	assign stem_ok   = 32'(items.payload.stem_index) < 32'(STEM_COUNT);
	assign is_sample = items.payload.req_type == REQ_SAMPLE;
	assign is_start  = items.payload.req_type == REQ_START;

	always_comb begin
		frames_next = frames_left_q;
		if (accept) begin
			case (req_t'(items.payload.req_type))
				REQ_START: begin
					frames_next = FL_W'(BLEND_LENGTH);
				end
				REQ_SAMPLE: begin
					if (items.payload.frame_end && frames_left_q != '0) begin
						frames_next = frames_left_q - FL_W'(1);
					end
				end
				default: begin
					frames_next = frames_left_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_left_q <= '0;
		end else begin
			frames_left_q <= frames_next;
		end
	end

	// weight for the countdown value held in frames_left_q
	stcf_weight_rom #(
		.BLEND_LENGTH(BLEND_LENGTH),
		.FL_W(FL_W)
	) u_rom (
		.clk(clk),
		.arst_n(arst_n),
		.addr(frames_next),
		.weight(w_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STEM_COUNT; k++) begin
				last_l_q[k] <= '0;
				last_r_q[k] <= '0;
				held_l_q[k] <= '0;
				held_r_q[k] <= '0;
			end
		end else if (accept) begin
			case (req_t'(items.payload.req_type))
				REQ_START: begin
					for (int k = 0; k < STEM_COUNT; k++) begin
						held_l_q[k] <= last_l_q[k];
						held_r_q[k] <= last_r_q[k];
					end
				end
				REQ_CLEAR: begin
					for (int k = 0; k < STEM_COUNT; k++) begin
						last_l_q[k] <= '0;
						last_r_q[k] <= '0;
					end
				end
				REQ_SAMPLE: begin
					if (stem_ok) begin
						last_l_q[stem_idx] <= items.payload.sample_left;
						last_r_q[stem_idx] <= items.payload.sample_right;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept && is_sample && stem_ok;
		end
	end

	// weight is zero when no transition runs, so the lanes pass live through
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			stem_s1   <= items.payload.stem_index;
			live_l_s1 <= items.payload.sample_left;
			live_r_s1 <= items.payload.sample_right;
			held_l_s1 <= held_l_q[stem_idx];
			held_r_s1 <= held_r_q[stem_idx];
			w_s1      <= w_cur;
			active_s1 <= frames_left_q != '0;
		end
	end

	stcf_blend_lane u_lane_l (
		.live(live_l_s1),
		.held(held_l_s1),
		.weight(w_s1),
		.blended(blend_l)
	);

	stcf_blend_lane u_lane_r (
		.live(live_r_s1),
		.held(held_r_s1),
		.weight(w_s1),
		.blended(blend_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_s2.stem_out  <= stem_s1;
			out_s2.out_left  <= blend_l;
			out_s2.out_right <= blend_r;
			out_s2.blending  <= active_s1;
		end
	end

	assign results.valid   = valid_s2;
	assign results.payload = out_s2;

	`STCF_ASSERT_SAME(a_frames_bound, 1'b1, frames_left_q <= FL_W'(BLEND_LENGTH), "countdown high")
	`STCF_ASSERT_NEXT(a_start_weight, accept && is_start, w_cur == W_ONE, "weight after start")
	`STCF_ASSERT_SAME(a_active_weight, valid_s1 && active_s1, w_s1 != '0, "zero weight in blend")
	`STCF_ASSERT_SAME(a_idle_weight, valid_s1 && !active_s1, w_s1 == '0, "weight while idle")

endmodule

`default_nettype wire

[tb/tb_stem_transition_crossfade_core.sv]
// ----------------------------------------------------------------------------
// tb_stem_transition_crossfade_core
// self-checking bench: a directed run of requests, then random frames of stem
// samples with starts, clears and unused codes mixed in; every result word is
// checked field by field against a crossfade predictor kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stem_transition_crossfade_core import stcf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLEND_LENGTH = 256;
	localparam int STEM_COUNT   = 8;
	localparam int RANDOM_WORDS = 1650;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 10;

	localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
	localparam sample_t SMAX = 24'sh7FFFFF;
	localparam sample_t SMIN = 24'sh800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stcf_chan_if #(.T(in_item_t))  items_if ();
	stcf_chan_if #(.T(out_item_t)) results_if ();

	stem_transition_crossfade_core #(
		.BLEND_LENGTH(BLEND_LENGTH),
		.STEM_COUNT(STEM_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// crossfade state as seen from outside
	sample_t     mem_left [STEM_COUNT];
	sample_t     mem_right[STEM_COUNT];
	sample_t     hold_left [STEM_COUNT];
	sample_t     hold_right[STEM_COUNT];
	int unsigned countdown;

	in_item_t  req_words[$];
	out_item_t mix_queue[$];
	out_item_t want;

	int errors = 0;
	int words_sent = 0;
	int words_recv = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int idle_cycles = 0;

	// floor(sqrt(remaining / BLEND_LENGTH)) in q1.15
	function automatic longint unsigned weight_q15(int unsigned remaining);
		longint unsigned q, r, c;
		q = (longint'(remaining) << 30) / BLEND_LENGTH;
		r = 0;
		for (int b = 16; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= q)
				r = c;
		end
		return r;
	endfunction

	function automatic sample_t lerp_toward(sample_t live, sample_t held, longint wt);
		longint d;
		d = longint'(held) - longint'(live);
		// arithmetic shift gives the floor for negative products
		return sample_t'(longint'(live) + ((wt * d) >>> FRAC));
	endfunction

	function automatic void predict_crossfade(in_item_t w);
		out_item_t o;
		longint wt;
		case (w.req_type)
			REQ_START: begin
				for (int k = 0; k < STEM_COUNT; k++) begin
					hold_left[k]  = mem_left[k];
					hold_right[k] = mem_right[k];
				end
				countdown = BLEND_LENGTH;
			end
			REQ_CLEAR: begin
				for (int k = 0; k < STEM_COUNT; k++) begin
					mem_left[k]  = '0;
					mem_right[k] = '0;
				end
			end
			REQ_SAMPLE: begin
				if (int'(w.stem_index) < STEM_COUNT) begin
					mem_left[w.stem_index]  = w.sample_left;
					mem_right[w.stem_index] = w.sample_right;
					o.stem_out  = w.stem_index;
					o.out_left  = w.sample_left;
					o.out_right = w.sample_right;
					o.blending  = 1'b0;
					if (countdown != 0) begin
						wt = longint'(weight_q15(countdown));
						o.out_left  = lerp_toward(w.sample_left, hold_left[w.stem_index], wt);
						o.out_right = lerp_toward(w.sample_right, hold_right[w.stem_index], wt);
						o.blending  = 1'b1;
					end
					mix_queue.push_back(o);
				end
				// blend above used the count from before this decrement
				if (w.frame_end && countdown != 0)
					countdown--;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int idle_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return SMAX;
		if (r == 1)
			return SMIN;
		if (r == 2)
			return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
		return sample_t'($urandom());
	endfunction

	task automatic push_word(logic [REQ_W-1:0] req, int stem, sample_t l, sample_t r, bit fe);
		in_item_t w;
		w.req_type     = req;
		w.stem_index   = STEM_W'(stem);
		w.sample_left  = l;
		w.sample_right = r;
		w.frame_end    = fe;
		req_words.push_back(w);
	endtask

	// driver: one word per handshake, random gaps between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid   <= 1'b0;
			items_if.payload <= '0;
			send_gap <= 0;
		end else begin
			if (items_if.valid && items_if.ready) begin
				predict_crossfade(items_if.payload);
				words_sent <= words_sent + 1;
			end
			if (!items_if.valid || items_if.ready) begin
				if (send_gap != 0) begin
					items_if.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (req_words.size() != 0) begin
					items_if.payload <= req_words.pop_front();
					items_if.valid   <= 1'b1;
					send_gap <= idle_gap(((words_sent / 120) % 4) == 3);
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, checks against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				words_recv <= words_recv + 1;
				if (mix_queue.size() == 0) begin
					$error("unexpected result word: stem_out %0d", results_if.payload.stem_out);
					errors++;
				end else begin
					want = mix_queue.pop_front();
					if (results_if.payload.stem_out !== want.stem_out) begin
						$error("stem_out: expected %0d, got %0d",
							want.stem_out, results_if.payload.stem_out);
						errors++;
					end
					if (results_if.payload.out_left !== want.out_left) begin
						$error("out_left: expected %0d, got %0d",
							want.out_left, results_if.payload.out_left);
						errors++;
					end
					if (results_if.payload.out_right !== want.out_right) begin
						$error("out_right: expected %0d, got %0d",
							want.out_right, results_if.payload.out_right);
						errors++;
					end
					if (results_if.payload.blending !== want.blending) begin
						$error("blending: expected %0d, got %0d",
							want.blending, results_if.payload.blending);
						errors++;
					end
				end
			end
			if (recv_gap != 0) begin
				results_if.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				results_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap <= idle_gap(((words_recv / 100) % 4) == 1);
			end
		end
	end

	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (!arst_n || idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("tb_stem_transition_crossfade_core NOT OK");
		$finish;
	end

	initial begin
		int r, nstem, total;
		bit broken;
		items_if.valid   = 1'b0;
		items_if.payload = '0;
		results_if.ready = 1'b0;
		for (int k = 0; k < STEM_COUNT; k++) begin
			mem_left[k]   = '0;
			mem_right[k]  = '0;
			hold_left[k]  = '0;
			hold_right[k] = '0;
		end
		countdown = 0;

		// pass-through before any transition, field extremes
		push_word(REQ_SAMPLE, 0, SMAX, SMAX, 1'b0);
		push_word(REQ_SAMPLE, 1, SMIN, SMIN, 1'b0);
		push_word(REQ_SAMPLE, 7, -24'sd1, 24'sd0, 1'b1);
		// unused code and frame_end on it are ignored
		push_word(REQ_RESERVED, 5, SMAX, SMIN, 1'b1);
		// start: first blend word returns the held sample exactly
		push_word(REQ_START, 3, SMIN, SMAX, 1'b1);
		push_word(REQ_SAMPLE, 0, SMIN, SMAX, 1'b0);
		push_word(REQ_SAMPLE, 1, SMAX, SMIN, 1'b1);
		push_word(REQ_SAMPLE, 7, SMAX, SMIN, 1'b1);
		// clear, then restart during the running blend
		push_word(REQ_CLEAR, 6, SMAX, SMAX, 1'b1);
		push_word(REQ_SAMPLE, 2, 24'sd123, -24'sd456, 1'b1);
		push_word(REQ_START, 0, 24'sd0, 24'sd0, 1'b0);
		push_word(REQ_SAMPLE, 0, SMAX, SMAX, 1'b1);
		push_word(REQ_SAMPLE, 3, SMIN, SMIN, 1'b0);
		for (int k = 0; k < STEM_COUNT; k++)
			push_word(REQ_SAMPLE, k, rand_sample(), rand_sample(), k == STEM_COUNT - 1);

		// random frames of a few stems, frame_end on the last one except in broken frames
		total = req_words.size() + RANDOM_WORDS;
		while (req_words.size() < total) begin
			r = $urandom_range(0, 999);
			if (r < 3) begin
				push_word(REQ_START, $urandom_range(0, 7), rand_sample(), rand_sample(),
					$urandom_range(0, 1));
			end else if (r < 13) begin
				push_word(REQ_CLEAR, $urandom_range(0, 7), rand_sample(), rand_sample(),
					$urandom_range(0, 1));
			end else if (r < 23) begin
				push_word(REQ_RESERVED, $urandom_range(0, 7), rand_sample(), rand_sample(),
					$urandom_range(0, 1));
			end else begin
				nstem = $urandom_range(1, 4);
				broken = ($urandom_range(0, 6) == 0);
				for (int k = 0; k < nstem; k++)
					push_word(REQ_SAMPLE, $urandom_range(0, STEM_COUNT - 1),
						rand_sample(), rand_sample(),
						broken ? bit'($urandom_range(0, 1)) : (k == nstem - 1));
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (req_words.size() != 0)
			@(posedge clk);
		@(posedge clk);
		while (items_if.valid)
			@(posedge clk);
		while (mix_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && mix_queue.size() == 0)
			$display("tb_stem_transition_crossfade_core OK");
		else
			$display("tb_stem_transition_crossfade_core NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
